// ----- rtl/core/nnfd_pkg.sv -----
// ---------------------------------------------------------------------------
// nnfd_pkg: shared types and constants of the fit downscaler
// Register map, controller states, command and status bundles, side clamp.
// ---------------------------------------------------------------------------
package nnfd_pkg;

   localparam int MAX_SIDE     = 1024;
   localparam int SIDE_W       = 11;
   localparam int COORD_W      = 10;
   localparam int PIXEL_W      = 32;
   localparam int FRAC_W       = 8;
   localparam int ROUND_HALF   = 128;
   localparam int DIVIDEND_W   = SIDE_W + FRAC_W;
   localparam int DIVISOR_W    = SIDE_W;
   localparam int PRODUCT_W    = SIDE_W + DIVIDEND_W;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;

   localparam logic [SIDE_W-1:0] RESET_SOURCE_WIDTH  = SIDE_W'(1);
   localparam logic [SIDE_W-1:0] RESET_SOURCE_HEIGHT = SIDE_W'(1);
   localparam logic [SIDE_W-1:0] RESET_BOX_WIDTH     = SIDE_W'(96);
   localparam logic [SIDE_W-1:0] RESET_BOX_HEIGHT    = SIDE_W'(96);

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT,
      REG_BOX_WIDTH,
      REG_BOX_HEIGHT
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_FX,
      ST_FX_WAIT,
      ST_FY,
      ST_FY_WAIT,
      ST_MUL_W,
      ST_MUL_H,
      ST_CQ,
      ST_CQ_WAIT,
      ST_RQ,
      ST_RQ_WAIT,
      ST_RUN
   } state_type;

   typedef enum logic [1:0] {
      DIV_FX,
      DIV_FY,
      DIV_CQ,
      DIV_RQ
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      logic        div_wait;
      div_sel_type div_sel;
      logic        mul_w;
      logic        mul_h;
      logic        run;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic scale;
   } status_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/nnfd_if.sv -----
// ---------------------------------------------------------------------------
// nnfd channel interfaces
// Valid/ready channels for source pixels in and selected pixels out.
// ---------------------------------------------------------------------------
interface nnfd_req_if;
   logic                            valid;
   logic                            ready;
   logic [nnfd_pkg::PIXEL_W-1:0]    pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface nnfd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nnfd_pkg::PIXEL_W-1:0]    pixel_out;
   logic [nnfd_pkg::COORD_W-1:0]    dest_x;
   logic [nnfd_pkg::COORD_W-1:0]    dest_y;
   logic [nnfd_pkg::SIDE_W-1:0]     dest_width;
   logic [nnfd_pkg::SIDE_W-1:0]     dest_height;
   logic                            frame_last;

   modport source (output valid, output pixel_out, output dest_x, output dest_y,
                   output dest_width, output dest_height, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input dest_x, input dest_y,
                   input dest_width, input dest_height, input frame_last,
                   output ready);
endinterface

// ----- rtl/core/nnfd_div.sv -----
// ---------------------------------------------------------------------------
// nnfd_div: shared restoring divider
// One quotient bit per cycle; done pulses one cycle when the result is ready.
// ---------------------------------------------------------------------------
module nnfd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [nnfd_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [nnfd_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                done,
   output logic [nnfd_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [nnfd_pkg::DIVISOR_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(nnfd_pkg::DIVIDEND_W + 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [nnfd_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [nnfd_pkg::DIVIDEND_W-1:0]     quo_ff, quo_in;
   logic [nnfd_pkg::DIVISOR_W-1:0]      divisor_ff, divisor_in;
   logic [nnfd_pkg::DIVISOR_W:0]        shifted;
   logic [nnfd_pkg::DIVISOR_W:0]        diff;
   logic                                fits;

   assign shifted = {rem_ff, quo_ff[nnfd_pkg::DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(nnfd_pkg::DIVIDEND_W);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[nnfd_pkg::DIVISOR_W-1:0] : shifted[nnfd_pkg::DIVISOR_W-1:0];
         quo_in   = {quo_ff[nnfd_pkg::DIVIDEND_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider not busy after start");

   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0)
      else $error("divider busy with zero count");

endmodule

// ----- rtl/core/nnfd_ctrl.sv -----
// ---------------------------------------------------------------------------
// nnfd_ctrl: setup sequencer
// Steps the datapath through the size and step computation, then streams.
// ---------------------------------------------------------------------------
module nnfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_write,
   input  nnfd_pkg::status_type   status,
   output nnfd_pkg::cmd_type      cmd
);

   nnfd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (cfg_write) begin
         state_in = nnfd_pkg::ST_LOAD;
      end else begin
         unique case (state_ff)
            nnfd_pkg::ST_LOAD:    state_in = nnfd_pkg::ST_CHECK;
            nnfd_pkg::ST_CHECK:   state_in = status.scale ? nnfd_pkg::ST_FX : nnfd_pkg::ST_CQ;
            nnfd_pkg::ST_FX:      state_in = nnfd_pkg::ST_FX_WAIT;
            nnfd_pkg::ST_FX_WAIT: if (status.div_done) begin
               state_in = nnfd_pkg::ST_FY;
            end
            nnfd_pkg::ST_FY:      state_in = nnfd_pkg::ST_FY_WAIT;
            nnfd_pkg::ST_FY_WAIT: if (status.div_done) begin
               state_in = nnfd_pkg::ST_MUL_W;
            end
            nnfd_pkg::ST_MUL_W:   state_in = nnfd_pkg::ST_MUL_H;
            nnfd_pkg::ST_MUL_H:   state_in = nnfd_pkg::ST_CQ;
            nnfd_pkg::ST_CQ:      state_in = nnfd_pkg::ST_CQ_WAIT;
            nnfd_pkg::ST_CQ_WAIT: if (status.div_done) begin
               state_in = nnfd_pkg::ST_RQ;
            end
            nnfd_pkg::ST_RQ:      state_in = nnfd_pkg::ST_RQ_WAIT;
            nnfd_pkg::ST_RQ_WAIT: if (status.div_done) begin
               state_in = nnfd_pkg::ST_RUN;
            end
            nnfd_pkg::ST_RUN:     state_in = nnfd_pkg::ST_RUN;
            default:              state_in = nnfd_pkg::ST_LOAD;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         nnfd_pkg::ST_LOAD:    cmd.load = 1'b1;
         nnfd_pkg::ST_CHECK:   cmd = '0;
         nnfd_pkg::ST_FX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = nnfd_pkg::DIV_FX;
         end
         nnfd_pkg::ST_FX_WAIT: begin
            cmd.div_wait = 1'b1;
            cmd.div_sel  = nnfd_pkg::DIV_FX;
         end
         nnfd_pkg::ST_FY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = nnfd_pkg::DIV_FY;
         end
         nnfd_pkg::ST_FY_WAIT: begin
            cmd.div_wait = 1'b1;
            cmd.div_sel  = nnfd_pkg::DIV_FY;
         end
         nnfd_pkg::ST_MUL_W:   cmd.mul_w = 1'b1;
         nnfd_pkg::ST_MUL_H:   cmd.mul_h = 1'b1;
         nnfd_pkg::ST_CQ: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = nnfd_pkg::DIV_CQ;
         end
         nnfd_pkg::ST_CQ_WAIT: begin
            cmd.div_wait = 1'b1;
            cmd.div_sel  = nnfd_pkg::DIV_CQ;
         end
         nnfd_pkg::ST_RQ: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = nnfd_pkg::DIV_RQ;
         end
         nnfd_pkg::ST_RQ_WAIT: begin
            cmd.div_wait = 1'b1;
            cmd.div_sel  = nnfd_pkg::DIV_RQ;
         end
         nnfd_pkg::ST_RUN:     cmd.run = 1'b1;
         default:              cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nnfd_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> state_ff == nnfd_pkg::ST_LOAD)
      else $error("configuration write did not restart setup");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nnfd_pkg::ST_CQ_WAIT && !status.div_done && !cfg_write)
      |=> state_ff == nnfd_pkg::ST_CQ_WAIT)
      else $error("left divider wait early");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_start, cmd.div_wait, cmd.mul_w, cmd.mul_h, cmd.run}))
      else $error("conflicting datapath commands");

endmodule

// ----- rtl/core/nnfd_datapath.sv -----
// ---------------------------------------------------------------------------
// nnfd_datapath: registers, size math and pixel selection
// Holds the configuration, derives the destination size and step constants,
// and walks the source raster to pick destination pixels.
// ---------------------------------------------------------------------------
module nnfd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  nnfd_pkg::cmd_type                   cmd,
   output nnfd_pkg::status_type                status,
   input  logic                                cfg_write,
   input  nnfd_pkg::reg_index_type             cfg_index,
   input  logic [nnfd_pkg::SIDE_W-1:0]         cfg_wdata,
   output logic [nnfd_pkg::SIDE_W-1:0]         cfg_rdata,
   nnfd_req_if.sink                            req_chan,
   nnfd_rsp_if.source                          rsp_chan
);

   localparam int SW = nnfd_pkg::SIDE_W;
   localparam int CW = nnfd_pkg::COORD_W;

   logic [SW-1:0] src_w_ff, src_h_ff, box_w_ff, box_h_ff;
   logic [SW-1:0] sw_ff, sh_ff, bw_ff, bh_ff;
   logic [SW-1:0] dw_ff, dh_ff;
   logic [nnfd_pkg::DIVIDEND_W-1:0] fx_ff, f_ff;
   logic [SW-1:0] col_quot_ff, col_rest_ff, row_quot_ff, row_rest_ff;

   logic [SW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [SW-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [SW-1:0] npc_ff, npc_in, npr_ff, npr_in;
   logic [SW-1:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [nnfd_pkg::PIXEL_W-1:0] pixel_ff;
   logic [CW-1:0]                dest_x_ff, dest_y_ff;
   logic                         last_ff;

   logic                                div_done;
   logic [nnfd_pkg::DIVIDEND_W-1:0]     div_quot;
   logic [nnfd_pkg::DIVISOR_W-1:0]      div_rem;
   logic [nnfd_pkg::DIVIDEND_W-1:0]     div_a;
   logic [nnfd_pkg::DIVISOR_W-1:0]      div_b;

   logic [SW-1:0]                       mul_side;
   logic [nnfd_pkg::PRODUCT_W-1:0]      product;
   logic [SW-1:0]                       scaled;

   logic          req_fire, row_sel, col_sel, pick, row_end, frame_end, last_pick;
   logic [SW:0]   col_sum, row_sum;
   logic          col_carry, row_carry;
   logic [SW-1:0] col_rem_next, row_rem_next;

   // configuration readback
   always_comb begin
      unique case (cfg_index)
         nnfd_pkg::REG_SOURCE_WIDTH:  cfg_rdata = src_w_ff;
         nnfd_pkg::REG_SOURCE_HEIGHT: cfg_rdata = src_h_ff;
         nnfd_pkg::REG_BOX_WIDTH:     cfg_rdata = box_w_ff;
         nnfd_pkg::REG_BOX_HEIGHT:    cfg_rdata = box_h_ff;
         default:                     cfg_rdata = '0;
      endcase
   end

   assign status.scale    = (sw_ff > bw_ff) || (sh_ff > bh_ff);
   assign status.div_done = div_done;

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         nnfd_pkg::DIV_FX: begin
            div_a = {bw_ff, nnfd_pkg::FRAC_W'(0)};
            div_b = sw_ff;
         end
         nnfd_pkg::DIV_FY: begin
            div_a = {bh_ff, nnfd_pkg::FRAC_W'(0)};
            div_b = sh_ff;
         end
         nnfd_pkg::DIV_CQ: begin
            div_a = nnfd_pkg::DIVIDEND_W'(sw_ff);
            div_b = dw_ff;
         end
         default: begin
            div_a = nnfd_pkg::DIVIDEND_W'(sh_ff);
            div_b = dh_ff;
         end
      endcase
   end

   nnfd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // rounded scaled side, at least one
   assign mul_side = cmd.mul_w ? sw_ff : sh_ff;
   assign product  = nnfd_pkg::PRODUCT_W'(mul_side) * nnfd_pkg::PRODUCT_W'(f_ff)
                   + nnfd_pkg::PRODUCT_W'(nnfd_pkg::ROUND_HALF);
   assign scaled   = (product[nnfd_pkg::FRAC_W +: SW] == '0) ? SW'(1)
                   : product[nnfd_pkg::FRAC_W +: SW];

   // raster walk
   assign req_chan.ready = cmd.run && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign row_sel        = (dst_row_ff < dh_ff) && (src_row_ff == npr_ff);
   assign col_sel        = (dst_col_ff < dw_ff) && (src_col_ff == npc_ff);
   assign pick           = row_sel && col_sel;
   assign row_end        = SW'(src_col_ff + SW'(1)) == sw_ff;
   assign frame_end      = SW'(src_row_ff + SW'(1)) == sh_ff;
   assign last_pick      = (SW'(dst_col_ff + SW'(1)) == dw_ff)
                        && (SW'(dst_row_ff + SW'(1)) == dh_ff);

   assign col_sum      = {1'b0, col_rem_ff} + {1'b0, col_rest_ff};
   assign col_carry    = col_sum >= {1'b0, dw_ff};
   assign col_rem_next = col_carry ? SW'(col_sum - {1'b0, dw_ff}) : col_sum[SW-1:0];
   assign row_sum      = {1'b0, row_rem_ff} + {1'b0, row_rest_ff};
   assign row_carry    = row_sum >= {1'b0, dh_ff};
   assign row_rem_next = row_carry ? SW'(row_sum - {1'b0, dh_ff}) : row_sum[SW-1:0];

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      dst_col_in   = dst_col_ff;
      dst_row_in   = dst_row_ff;
      npc_in       = npc_ff;
      npr_in       = npr_ff;
      col_rem_in   = col_rem_ff;
      row_rem_in   = row_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (cmd.load) begin
         src_col_in = '0;
         src_row_in = '0;
         dst_col_in = '0;
         dst_row_in = '0;
         npc_in     = '0;
         npr_in     = '0;
         col_rem_in = '0;
         row_rem_in = '0;
      end else if (req_fire) begin
         if (pick) begin
            rsp_valid_in = 1'b1;
            dst_col_in   = SW'(dst_col_ff + SW'(1));
            npc_in       = SW'(npc_ff + col_quot_ff + SW'(col_carry));
            col_rem_in   = col_rem_next;
         end
         if (row_end) begin
            src_col_in = '0;
            dst_col_in = '0;
            npc_in     = '0;
            col_rem_in = '0;
            src_row_in = SW'(src_row_ff + SW'(1));
            if (row_sel) begin
               dst_row_in = SW'(dst_row_ff + SW'(1));
               npr_in     = SW'(npr_ff + row_quot_ff + SW'(row_carry));
               row_rem_in = row_rem_next;
            end
            if (frame_end) begin
               src_row_in = '0;
               dst_row_in = '0;
               npr_in     = '0;
               row_rem_in = '0;
            end
         end else begin
            src_col_in = SW'(src_col_ff + SW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff     <= nnfd_pkg::RESET_SOURCE_WIDTH;
         src_h_ff     <= nnfd_pkg::RESET_SOURCE_HEIGHT;
         box_w_ff     <= nnfd_pkg::RESET_BOX_WIDTH;
         box_h_ff     <= nnfd_pkg::RESET_BOX_HEIGHT;
         dw_ff        <= SW'(1);
         dh_ff        <= SW'(1);
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         dst_col_ff   <= '0;
         dst_row_ff   <= '0;
         npc_ff       <= '0;
         npr_ff       <= '0;
         col_rem_ff   <= '0;
         row_rem_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            unique case (cfg_index)
               nnfd_pkg::REG_SOURCE_WIDTH:  src_w_ff <= cfg_wdata;
               nnfd_pkg::REG_SOURCE_HEIGHT: src_h_ff <= cfg_wdata;
               nnfd_pkg::REG_BOX_WIDTH:     box_w_ff <= cfg_wdata;
               nnfd_pkg::REG_BOX_HEIGHT:    box_h_ff <= cfg_wdata;
               default:                     src_w_ff <= src_w_ff;
            endcase
         end
         if (cmd.load) begin
            dw_ff <= nnfd_pkg::clamp_side(src_w_ff);
            dh_ff <= nnfd_pkg::clamp_side(src_h_ff);
         end else if (cmd.mul_w) begin
            dw_ff <= scaled;
         end else if (cmd.mul_h) begin
            dh_ff <= scaled;
         end
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         dst_col_ff   <= dst_col_in;
         dst_row_ff   <= dst_row_in;
         npc_ff       <= npc_in;
         npr_ff       <= npr_in;
         col_rem_ff   <= col_rem_in;
         row_rem_ff   <= row_rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // clamped sides, per-frame constants and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sw_ff <= nnfd_pkg::clamp_side(src_w_ff);
         sh_ff <= nnfd_pkg::clamp_side(src_h_ff);
         bw_ff <= nnfd_pkg::clamp_side(box_w_ff);
         bh_ff <= nnfd_pkg::clamp_side(box_h_ff);
      end
      if (cmd.div_wait && div_done) begin
         case (cmd.div_sel)
            nnfd_pkg::DIV_FX: fx_ff <= div_quot;
            nnfd_pkg::DIV_FY: f_ff  <= (fx_ff < div_quot) ? fx_ff : div_quot;
            nnfd_pkg::DIV_CQ: begin
               col_quot_ff <= div_quot[SW-1:0];
               col_rest_ff <= div_rem;
            end
            default: begin
               row_quot_ff <= div_quot[SW-1:0];
               row_rest_ff <= div_rem;
            end
         endcase
      end
      if (req_fire && pick) begin
         pixel_ff  <= req_chan.pixel_in;
         dest_x_ff <= dst_col_ff[CW-1:0];
         dest_y_ff <= dst_row_ff[CW-1:0];
         last_ff   <= last_pick;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_out   = pixel_ff;
   assign rsp_chan.dest_x      = dest_x_ff;
   assign rsp_chan.dest_y      = dest_y_ff;
   assign rsp_chan.dest_width  = dw_ff;
   assign rsp_chan.dest_height = dh_ff;
   assign rsp_chan.frame_last  = last_ff;

   a_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> cmd.run)
      else $error("item accepted outside streaming");

   a_dest_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, dest_x_ff} < dw_ff) && ({1'b0, dest_y_ff} < dh_ff))
      else $error("destination coordinate out of range");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (src_col_ff == '0) && (src_row_ff == '0) && (dst_row_ff == '0))
      else $error("frame counters not cleared on load");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (SW'({1'b0, dest_x_ff} + SW'(1)) == dw_ff))
      else $error("frame end mark off the last column");

endmodule

// ----- rtl/core/nearest_neighbor_fit_downscaler.sv -----
// ---------------------------------------------------------------------------
// nearest_neighbor_fit_downscaler: fit-to-box nearest-neighbor pixel picker
// Scales a row-major ARGB source stream down to fit a box, forwarding only
// the picked source pixels tagged with destination coordinates.
//
//   channel   dir  handshake             payload
//   req_chan  in   valid/ready           pixel_in
//   rsp_chan  out  valid/ready           pixel_out, dest_x/y, dest_width/height,
//                                        frame_last
//   csr_*     in   APB write, pready=1   source/box width and height
//
// Streaming: one source item per cycle, results go through one output register.
// Setup after reset or any register write runs on the shared one-bit-per-cycle
// divider: two divisions without scaling, four with scaling plus the width and
// height multiply steps; req_chan.ready stays low meanwhile.
// A stalled result holds req_chan.ready low until it is taken.
// Reset is synchronous, clears the frame counters and sets the registers to their reset values.
// ---------------------------------------------------------------------------
module nearest_neighbor_fit_downscaler (
   input  logic                                clock,
   input  logic                                reset,
   nnfd_req_if.sink                            req_chan,
   nnfd_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nnfd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nnfd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nnfd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   nnfd_pkg::cmd_type          cmd;
   nnfd_pkg::status_type       status;
   nnfd_pkg::reg_index_type    cfg_index;
   logic                       cfg_write;
   logic [nnfd_pkg::SIDE_W-1:0] cfg_rdata;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = nnfd_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_prdata = nnfd_pkg::CSR_DATA_W'(cfg_rdata);

   nnfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .status    (status),
      .cmd       (cmd)
   );

   nnfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg_write (cfg_write),
      .cfg_index (cfg_index),
      .cfg_wdata (csr_pwdata[nnfd_pkg::SIDE_W-1:0]),
      .cfg_rdata (cfg_rdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

endmodule
